/* hdl/nret_pkg.sv */
// ----------------------------------------------------------------------------
// nret_pkg
// Shared types, codes and defaults for the nested region exclusive timer.
// ----------------------------------------------------------------------------
package nret_pkg;

  // Default sizes
  localparam int STACK_DEPTH_DEF  = 32;
  localparam int REGION_COUNT_DEF = 256;

  // Field widths
  localparam int OP_W   = 3;
  localparam int ID_W   = 8;
  localparam int TS_W   = 63;
  localparam int DATA_W = 64;

  // Operation codes
  localparam logic [OP_W-1:0] OP_SCOP_ENTER   = 3'd0;
  localparam logic [OP_W-1:0] OP_SCOP_EXIT    = 3'd1;
  localparam logic [OP_W-1:0] OP_REGION_ENTER = 3'd2;
  localparam logic [OP_W-1:0] OP_REGION_EXIT  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_TOTAL   = 3'd4;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_PUSH,
    ST_RD_FRAME,
    ST_CMP,
    ST_FULL,
    ST_EXCL,
    ST_PARENT,
    ST_SCOP,
    ST_TABLE,
    ST_PROG,
    ST_READ,
    ST_DONE
  } state_t;

  // Which operation the shared adder performs this cycle
  typedef enum logic [2:0] {
    ALU_NONE,
    ALU_FULL,
    ALU_EXCL,
    ALU_PARENT,
    ALU_SCOP,
    ALU_TABLE,
    ALU_PROG
  } alu_sel_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic            in_valid;
    logic [OP_W-1:0] op;
    logic            sp_zero;
    logic            sp_one;
    logic            sp_full;
    logic            frame_hit;
    logic            prog_hit;
    logic            id_in_range;
    logic            clr_last;
    logic            out_free;
  } status_t;

  // Sequencer controls to the datapath
  typedef struct packed {
    logic     in_ready;
    logic     clr_we;
    logic     push;
    logic     pop;
    logic     frame_rd;
    logic     child_rd_top;
    logic     child_rd_parent;
    logic     tbl_rd;
    logic     set_overflow;
    logic     set_matched;
    logic     out_load;
    alu_sel_t alu_sel;
  } ctrl_t;

endpackage

/* hdl/nret_ram.sv */
// ----------------------------------------------------------------------------
// nret_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nret_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/nret_alu.sv */
// ----------------------------------------------------------------------------
// nret_alu
// Shared 64-bit adder/subtractor, reused by the arithmetic steps of the sequencer.
// ----------------------------------------------------------------------------
module nret_alu (
  input  logic [nret_pkg::DATA_W-1:0] a,
  input  logic [nret_pkg::DATA_W-1:0] b,
  input  logic                        sub,
  output logic [nret_pkg::DATA_W-1:0] sum
);
  import nret_pkg::*;

  logic [DATA_W-1:0] b_eff;

  // Two's complement subtract by inverting b and carrying in one
  always_comb begin
    b_eff = sub ? ~b : b;
    sum   = a + b_eff + DATA_W'(sub);
  end

endmodule

/* hdl/nret_ctrl.sv */
// ----------------------------------------------------------------------------
// nret_ctrl
// Sequencer: table clear after reset, then push, unwind, credit, read and program steps per word.
// ----------------------------------------------------------------------------
module nret_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  nret_pkg::status_t status,
  output nret_pkg::ctrl_t   ctrl
);
  import nret_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:    if (status.clr_last) state_next = ST_IDLE;
      ST_IDLE:     if (status.in_valid) state_next = ST_DECODE;
      ST_DECODE: begin
        case (status.op)
          OP_SCOP_ENTER:   state_next = status.sp_full ? ST_DONE : ST_PUSH;
          OP_SCOP_EXIT:    state_next = status.sp_zero ? ST_DONE : ST_RD_FRAME;
          OP_REGION_ENTER: state_next = status.prog_hit ? ST_PROG : ST_DONE;
          OP_REGION_EXIT:  state_next = status.prog_hit ? ST_PROG : ST_DONE;
          OP_READ_TOTAL:   state_next = status.id_in_range ? ST_READ : ST_DONE;
          default:         state_next = ST_DONE;
        endcase
      end
      ST_PUSH:     state_next = ST_DONE;
      ST_RD_FRAME: state_next = ST_CMP;
      ST_CMP: begin
        if (status.frame_hit) begin
          state_next = ST_FULL;
        end else if (status.sp_one) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_RD_FRAME;
        end
      end
      ST_FULL:     state_next = ST_EXCL;
      ST_EXCL:     state_next = ST_PARENT;
      ST_PARENT:   state_next = ST_SCOP;
      ST_SCOP:     state_next = status.id_in_range ? ST_TABLE : ST_DONE;
      ST_TABLE:    state_next = ST_DONE;
      ST_PROG:     state_next = ST_DONE;
      ST_READ:     state_next = ST_DONE;
      ST_DONE:     if (status.out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl = '0;
    ctrl.alu_sel = ALU_NONE;
    case (state)
      ST_CLEAR:    ctrl.clr_we = 1'b1;
      ST_IDLE:     ctrl.in_ready = 1'b1;
      ST_DECODE: begin
        if (status.op == OP_SCOP_ENTER && status.sp_full) begin
          ctrl.set_overflow = 1'b1;
        end
      end
      ST_PUSH:     ctrl.push = 1'b1;
      ST_RD_FRAME: ctrl.frame_rd = 1'b1;
      ST_CMP: begin
        // hit: fetch child time of the top frame; miss: discard the frame unless it is the last one
        if (status.frame_hit) begin
          ctrl.child_rd_top = 1'b1;
        end else if (!status.sp_one) begin
          ctrl.pop = 1'b1;
        end
      end
      ST_FULL:     ctrl.alu_sel = ALU_FULL;
      ST_EXCL: begin
        ctrl.alu_sel         = ALU_EXCL;
        ctrl.child_rd_parent = 1'b1;
      end
      ST_PARENT: begin
        ctrl.alu_sel     = ALU_PARENT;
        ctrl.pop         = 1'b1;
        ctrl.tbl_rd      = 1'b1;
        ctrl.set_matched = 1'b1;
      end
      ST_SCOP:     ctrl.alu_sel = ALU_SCOP;
      ST_TABLE:    ctrl.alu_sel = ALU_TABLE;
      ST_PROG:     ctrl.alu_sel = ALU_PROG;
      ST_READ:     ctrl.tbl_rd = 1'b1;
      ST_DONE:     ctrl.out_load = status.out_free;
      default:     ctrl.alu_sel = ALU_NONE;
    endcase
  end

endmodule

/* hdl/nested_region_exclusive_timer.sv */
// ----------------------------------------------------------------------------
// nested_region_exclusive_timer
// Exclusive self-time profiler over a shadow stack of nested regions.
// ----------------------------------------------------------------------------
// Takes one trace word at a time and returns one result word for each. A
// single 64-bit adder is shared by all arithmetic steps and the frame, child
// time and region tables sit in single-read-port RAMs, so the sequencer walks
// each word through them. A pushed enter takes a push step, an in-range read
// a table read and a program region event a program total update; other words
// go straight to the result. An exit compares frames from the top, discarding
// each mismatched one but the last; on a hit it computes full and exclusive
// time, credits the parent, pops the frame and adds to the scop total and, for
// an in-range id, the region table. The next word can be taken in the cycle
// after the result is loaded. A result stalled in the output register holds
// the sequencer in its last step. After reset the region table is swept to
// zero, one entry a cycle, over all REGION_COUNT entries before the first word
// is accepted. Write program_region_id only while no word is in flight.
module nested_region_exclusive_timer #(
  parameter int STACK_DEPTH  = nret_pkg::STACK_DEPTH_DEF,
  parameter int REGION_COUNT = nret_pkg::REGION_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [nret_pkg::ID_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [nret_pkg::OP_W-1:0]          operation,
  input  logic [nret_pkg::ID_W-1:0]          region_id,
  input  logic [nret_pkg::TS_W-1:0]          timestamp,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [nret_pkg::DATA_W-1:0] exclusive_time,
  output logic signed [nret_pkg::DATA_W-1:0] scop_time_total,
  output logic signed [nret_pkg::DATA_W-1:0] program_time_total,
  output logic                               exit_matched,
  output logic                               stack_overflow,
  output logic signed [nret_pkg::DATA_W-1:0] region_total
);
  import nret_pkg::*;

  localparam int SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int FR_AW = $clog2(STACK_DEPTH);
  localparam int TB_AW = $clog2(REGION_COUNT);
  localparam int FR_W  = ID_W + TS_W;

  status_t status;
  ctrl_t   ctrl;

  logic [ID_W-1:0]   program_region_id;
  logic [OP_W-1:0]   item_op;
  logic [ID_W-1:0]   item_id;
  logic [TS_W-1:0]   item_ts;
  logic [SP_W-1:0]   sp;
  logic [DATA_W-1:0] full_time;
  logic [DATA_W-1:0] excl_time;
  logic [DATA_W-1:0] scop_total;
  logic [DATA_W-1:0] program_total;
  logic              matched;
  logic              overflow;
  logic [TB_AW-1:0]  clr_cnt;

  logic [FR_W-1:0]   frame_rdata;
  logic [ID_W-1:0]   frame_id;
  logic [TS_W-1:0]   frame_ts;
  logic [DATA_W-1:0] child_rdata;
  logic [DATA_W-1:0] tbl_rdata;
  logic [SP_W-1:0]   sp_dec;
  logic [SP_W-1:0]   sp_inc;
  logic [TB_AW-1:0]  item_addr;
  logic              id_in_range;
  logic              in_take;

  logic [DATA_W-1:0] alu_a;
  logic [DATA_W-1:0] alu_b;
  logic              alu_sub;
  logic [DATA_W-1:0] alu_sum;

  logic              child_we;
  logic [SP_W-1:0]   child_waddr;
  logic [DATA_W-1:0] child_wdata;
  logic              child_re;
  logic [SP_W-1:0]   child_raddr;
  logic              tbl_we;
  logic [TB_AW-1:0]  tbl_waddr;
  logic [DATA_W-1:0] tbl_wdata;

  // Common address and compare terms
  assign sp_dec      = sp - SP_W'(1);
  assign sp_inc      = sp + SP_W'(1);
  assign item_addr   = TB_AW'(item_id);
  assign id_in_range = 32'(item_id) < REGION_COUNT;
  assign frame_id    = frame_rdata[FR_W-1:TS_W];
  assign frame_ts    = frame_rdata[TS_W-1:0];
  assign in_take     = ctrl.in_ready && in_valid;
  assign in_stall    = !ctrl.in_ready;

  // Status to the sequencer
  always_comb begin
    status.in_valid    = in_valid;
    status.op          = item_op;
    status.sp_zero     = sp == '0;
    status.sp_one      = sp == SP_W'(1);
    status.sp_full     = sp == SP_W'(STACK_DEPTH);
    status.frame_hit   = frame_id == item_id;
    status.prog_hit    = item_id == program_region_id;
    status.id_in_range = id_in_range;
    status.clr_last    = clr_cnt == TB_AW'(REGION_COUNT - 1);
    status.out_free    = !out_valid || !out_stall;
  end

  nret_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // Operand selection for the shared adder
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (ctrl.alu_sel)
      ALU_FULL: begin
        alu_a   = {1'b0, item_ts};
        alu_b   = {1'b0, frame_ts};
        alu_sub = 1'b1;
      end
      ALU_EXCL: begin
        alu_a   = full_time;
        alu_b   = child_rdata;
        alu_sub = 1'b1;
      end
      ALU_PARENT: begin
        alu_a = child_rdata;
        alu_b = full_time;
      end
      ALU_SCOP: begin
        alu_a = scop_total;
        alu_b = excl_time;
      end
      ALU_TABLE: begin
        alu_a = tbl_rdata;
        alu_b = excl_time;
      end
      ALU_PROG: begin
        alu_a   = program_total;
        alu_b   = {1'b0, item_ts};
        alu_sub = item_op == OP_REGION_ENTER;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  nret_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum)
  );

  // Frame RAM: region id and start time of each open frame
  nret_ram #(
    .WIDTH (FR_W),
    .DEPTH (STACK_DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ctrl.push),
    .waddr (FR_AW'(sp)),
    .wdata ({item_id, item_ts}),
    .re    (ctrl.frame_rd),
    .raddr (FR_AW'(sp_dec)),
    .rdata (frame_rdata)
  );

  // Child time RAM: entry k belongs to frame k, entry 0 is the base slot
  assign child_we    = ctrl.push || (ctrl.alu_sel == ALU_PARENT);
  assign child_waddr = ctrl.push ? sp_inc : sp_dec;
  assign child_wdata = ctrl.push ? '0 : alu_sum;
  assign child_re    = ctrl.child_rd_top || ctrl.child_rd_parent;
  assign child_raddr = ctrl.child_rd_top ? sp : sp_dec;

  nret_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH + 1)
  ) u_child_ram (
    .clk   (clk),
    .we    (child_we),
    .waddr (child_waddr),
    .wdata (child_wdata),
    .re    (child_re),
    .raddr (child_raddr),
    .rdata (child_rdata)
  );

  // Region table RAM, swept to zero after reset
  assign tbl_we    = ctrl.clr_we || (ctrl.alu_sel == ALU_TABLE);
  assign tbl_waddr = ctrl.clr_we ? clr_cnt : item_addr;
  assign tbl_wdata = ctrl.clr_we ? '0 : alu_sum;

  nret_ram #(
    .WIDTH (DATA_W),
    .DEPTH (REGION_COUNT)
  ) u_table_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (ctrl.tbl_rd),
    .raddr (item_addr),
    .rdata (tbl_rdata)
  );

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      program_region_id <= '0;
    end else if (cfg_write) begin
      program_region_id <= cfg_data;
    end
  end

  // Clear sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (ctrl.clr_we) begin
      clr_cnt <= clr_cnt + TB_AW'(1);
    end
  end

  // Captured input word
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_op <= operation;
      item_id <= region_id;
      item_ts <= timestamp;
    end
  end

  // Per-word flags
  always_ff @(posedge clk) begin
    if (rst) begin
      matched  <= 1'b0;
      overflow <= 1'b0;
    end else if (in_take) begin
      matched  <= 1'b0;
      overflow <= 1'b0;
    end else begin
      if (ctrl.set_matched) matched <= 1'b1;
      if (ctrl.set_overflow) overflow <= 1'b1;
    end
  end

  // Stack pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (ctrl.push) begin
      sp <= sp_inc;
    end else if (ctrl.pop) begin
      sp <= sp_dec;
    end
  end

  // Adder result registers: intermediate durations
  always_ff @(posedge clk) begin
    if (ctrl.alu_sel == ALU_FULL) full_time <= alu_sum;
    if (ctrl.alu_sel == ALU_EXCL) excl_time <= alu_sum;
  end

  // Running totals
  always_ff @(posedge clk) begin
    if (rst) begin
      scop_total    <= '0;
      program_total <= '0;
    end else begin
      if (ctrl.alu_sel == ALU_SCOP) scop_total <= alu_sum;
      if (ctrl.alu_sel == ALU_PROG) program_total <= alu_sum;
    end
  end

  // Output register: valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      exclusive_time     <= matched ? $signed(excl_time) : '0;
      scop_time_total    <= $signed(scop_total);
      program_time_total <= $signed(program_total);
      exit_matched       <= matched;
      stack_overflow     <= overflow;
      region_total       <= (item_op == OP_READ_TOTAL && id_in_range) ?
                            $signed(tbl_rdata) : '0;
    end
  end

  // Checks
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    ctrl.clr_we |-> in_stall)
    else $error("input accepted during table clear");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(exit_matched && stack_overflow))
    else $error("exit match and overflow in one result");

  a_push_step: assert property (@(posedge clk) disable iff (rst)
    ctrl.push |=> sp == $past(sp) + SP_W'(1))
    else $error("push did not advance stack pointer");

  a_excl_needs_match: assert property (@(posedge clk) disable iff (rst)
    (out_valid && exclusive_time != '0) |-> exit_matched)
    else $error("exclusive time without matched exit");

endmodule
